/* src/binomial_coefficient_top_macros.svh */
// Assertion macros for the binomial coefficient block.
// Used by binomial_coefficient_top.sv; expects clk_i and rst_ni in scope.
`ifndef BINOMIAL_COEFFICIENT_TOP_MACROS_SVH
`define BINOMIAL_COEFFICIENT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define BC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication into the next cycle.
`define BC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BC_ASSERT_IMP(lbl, ante, cons, msg)
`define BC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* src/bc_pkg.sv */
// Shared widths, microcode types and the control store of the binomial coefficient block.
// No dependencies.
package bc_pkg;

  localparam int unsigned N_W     = 6;   // width of n and k
  localparam int unsigned COEF_W  = 60;  // width of the result
  localparam int unsigned REM_W   = 5;   // divisor j and reduced k stay below 32
  localparam int unsigned J_W     = REM_W + 1;
  localparam int unsigned DIGIT_W = 8;   // quotient bits per divide cycle
  localparam int unsigned PROD_W  = 72;  // acc * top (66 bits) padded to whole digits
  localparam int unsigned UPC_W   = 4;

  localparam logic [N_W-1:0] MAX_N = 6'd63;

  // Program labels
  localparam logic [UPC_W-1:0] L_LOAD     = 4'd0;
  localparam logic [UPC_W-1:0] L_TEST     = 4'd1;
  localparam logic [UPC_W-1:0] L_MUL      = 4'd2;
  localparam logic [UPC_W-1:0] L_DIV_FIRST = 4'd3;
  localparam logic [UPC_W-1:0] L_DIV_LAST = 4'd11;  // PROD_W / DIGIT_W divide steps
  localparam logic [UPC_W-1:0] L_NEXT     = 4'd12;
  localparam logic [UPC_W-1:0] L_OUT      = 4'd13;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_NEXT,
    OP_OUT
  } uop_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_LOOP_END
  } jcond_e;

  typedef struct packed {
    uop_e             op;
    jcond_e           jc;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic next;
  } bc_ctrl_t;

  // Control store: one word per program step.
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_NOP, jc: JC_ALWAYS, target: L_LOAD};
    unique case (upc) inside
      L_LOAD:                   w = '{op: OP_LOAD, jc: JC_NONE,     target: L_LOAD};
      L_TEST:                   w = '{op: OP_NOP,  jc: JC_LOOP_END, target: L_OUT};
      L_MUL:                    w = '{op: OP_MUL,  jc: JC_NONE,     target: L_LOAD};
      [L_DIV_FIRST:L_DIV_LAST]: w = '{op: OP_DIV,  jc: JC_NONE,     target: L_LOAD};
      L_NEXT:                   w = '{op: OP_NEXT, jc: JC_ALWAYS,   target: L_TEST};
      L_OUT:                    w = '{op: OP_OUT,  jc: JC_ALWAYS,   target: L_LOAD};
      default:                  w = '{op: OP_NOP,  jc: JC_ALWAYS,   target: L_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* src/bc_datapath.sv */
// Datapath of the binomial coefficient block: running product, counters,
// multiplier and byte-serial exact divider. Depends on bc_pkg.
module bc_datapath import bc_pkg::*; (
  input  logic              clk_i,
  input  bc_ctrl_t          ctrl_i,
  input  logic [N_W-1:0]    set_size_i,
  input  logic [N_W-1:0]    pick_count_i,
  output logic              loop_end_o,
  output logic [COEF_W-1:0] acc_o
);

  logic [COEF_W-1:0]     acc_q, acc_d;
  logic [N_W-1:0]        top_q, top_d;
  logic [J_W-1:0]        j_q, j_d;
  logic [REM_W-1:0]      kk_q, kk_d;
  logic [PROD_W-1:0]     sh_q, sh_d;
  logic [REM_W-1:0]      rem_q, rem_d;

  logic [N_W-1:0]        n_sat;
  logic [N_W-1:0]        n_minus_k;
  logic [COEF_W+N_W-1:0] prod;
  logic [REM_W-1:0]      dvs;
  logic [REM_W-1:0]      div_rem;
  logic [DIGIT_W-1:0]    div_q;

  assign n_sat     = (set_size_i > MAX_N) ? MAX_N : set_size_i;
  assign n_minus_k = n_sat - pick_count_i;
  assign prod      = acc_q * top_q;
  assign dvs       = j_q[REM_W-1:0];

  // Eight restoring steps on a remainder that stays below the divisor.
  always_comb begin
    logic [REM_W:0] t;
    logic [REM_W-1:0] r;
    r     = rem_q;
    div_q = '0;
    for (int b = 0; b < DIGIT_W; b++) begin
      t = {r, sh_q[PROD_W-1-b]};
      if (t >= {1'b0, dvs}) begin
        r = REM_W'(t - {1'b0, dvs});
        div_q[DIGIT_W-1-b] = 1'b1;
      end else begin
        r = t[REM_W-1:0];
      end
    end
    div_rem = r;
  end

  always_comb begin
    acc_d = acc_q;
    top_d = top_q;
    j_d   = j_q;
    kk_d  = kk_q;
    sh_d  = sh_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      acc_d = COEF_W'(1);
      top_d = n_sat;
      j_d   = J_W'(1);
      // k above n leaves the loop empty; otherwise use the smaller of k and n-k
      if (pick_count_i > n_sat) begin
        kk_d = '0;
      end else if (pick_count_i > n_minus_k) begin
        kk_d = n_minus_k[REM_W-1:0];
      end else begin
        kk_d = pick_count_i[REM_W-1:0];
      end
    end
    if (ctrl_i.mul) begin
      sh_d  = {{(PROD_W-COEF_W-N_W){1'b0}}, prod};
      rem_d = '0;
    end
    if (ctrl_i.div) begin
      sh_d  = {sh_q[PROD_W-DIGIT_W-1:0], div_q};
      rem_d = div_rem;
    end
    if (ctrl_i.next) begin
      acc_d = sh_q[COEF_W-1:0];
      top_d = top_q - N_W'(1);
      j_d   = j_q + J_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    top_q <= top_d;
    j_q   <= j_d;
    kk_q  <= kk_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign loop_end_o = j_q > {1'b0, kk_q};
  assign acc_o      = acc_q;

endmodule

/* src/binomial_coefficient_top.sv */
// Binomial coefficient C(n, k) by the multiplicative form, microcoded.
// Result after m = min(k, n-k) loop passes, m = 0 when k > n. One item is in flight at a
// time: the load step follows the output step, so no new input is taken before the result
// has entered the output register.
// The 12-step loop body is set by the shared 60x6 multiplier and the byte-serial divider.
// Reset: sequencer returns to the load step and the output register empties.
`include "binomial_coefficient_top_macros.svh"

module binomial_coefficient_top import bc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [N_W-1:0]    set_size_i,
  input  logic [N_W-1:0]    pick_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [COEF_W-1:0] coefficient_o
);

  // Micro-sequencer: the step counter addresses the control store in bc_pkg.
  logic [UPC_W-1:0]  upc_q, upc_d;
  uword_t            uw;
  bc_ctrl_t          ctrl;
  logic              loop_end;
  logic [COEF_W-1:0] acc;

  // Output register, parts the result side from the sequencer.
  logic              out_valid_q, out_valid_d;
  logic [COEF_W-1:0] coef_q, coef_d;

  logic out_free;
  logic stall;
  logic jump;

  assign uw       = ucode(upc_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Hold the load step until a transaction arrives; hold the output step while
  // the previous result is still waiting.
  assign stall = ((uw.op == OP_LOAD) && !in_valid_i) ||
                 ((uw.op == OP_OUT) && !out_free);
  assign jump  = (uw.jc == JC_ALWAYS) || ((uw.jc == JC_LOOP_END) && loop_end);

  always_comb begin
    if (stall) begin
      upc_d = upc_q;
    end else if (jump) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + UPC_W'(1);
    end
  end

  assign ctrl.load = (uw.op == OP_LOAD) && in_valid_i;
  assign ctrl.mul  = (uw.op == OP_MUL);
  assign ctrl.div  = (uw.op == OP_DIV);
  assign ctrl.next = (uw.op == OP_NEXT);

  bc_datapath u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .set_size_i   (set_size_i),
    .pick_count_i (pick_count_i),
    .loop_end_o   (loop_end),
    .acc_o        (acc)
  );

  // Drop the result flag once it is taken; load a new result at the output step.
  always_comb begin
    out_valid_d = out_valid_q;
    coef_d      = coef_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((uw.op == OP_OUT) && out_free) begin
      out_valid_d = 1'b1;
      coef_d      = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= L_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign in_ready_o    = (uw.op == OP_LOAD);
  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;

  // An accepted transaction always moves the sequencer into the loop test.
  `BC_ASSERT_NXT(a_load_to_test, in_valid_i && in_ready_o, upc_q == L_TEST, "load did not advance")
  // A blocked output step keeps the sequencer parked there.
  `BC_ASSERT_NXT(a_out_hold, (upc_q == L_OUT) && out_valid_o && !out_ready_i,
                 upc_q == L_OUT, "output step left while result stalled")
  // The step counter never leaves the program.
  `BC_ASSERT_IMP(a_upc_range, 1'b1, upc_q <= L_OUT, "step counter outside program")

endmodule

/* dv/binomial_coefficient_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for binomial_coefficient_top: predicts C(n, k) for every input transaction
// and checks every output transaction against the oldest prediction. Depends on bc_pkg.
module binomial_coefficient_checker import bc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [N_W-1:0]    set_size_i,
  input  logic [N_W-1:0]    pick_count_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [COEF_W-1:0] coefficient_i,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       mismatches_o
);

  localparam int unsigned MAX_REPORTS = 10;

  logic [COEF_W-1:0] coef_expected_q[$];
  int unsigned       checked_cnt;
  int unsigned       mismatch_cnt;

  // Ascending product C(n-m+i, i); 128 bits hold acc * (n-m+i) without overflow.
  function automatic logic [COEF_W-1:0] binomial_of(logic [N_W-1:0] n_in,
                                                    logic [N_W-1:0] k_in);
    logic [127:0]   acc;
    logic [N_W-1:0] n;
    logic [N_W-1:0] m;
    n = (n_in > MAX_N) ? MAX_N : n_in;
    if (k_in > n) return COEF_W'(1);
    m   = (k_in > n - k_in) ? n - k_in : k_in;
    acc = 128'd1;
    for (int i = 1; i <= m; i++) begin
      acc = (acc * 128'(n - m + i)) / 128'(i);
    end
    return acc[COEF_W-1:0];
  endfunction

  task automatic log_mismatch(string what, logic [COEF_W-1:0] exp_v, logic [COEF_W-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_expected_q.delete();
      checked_cnt  = 0;
      mismatch_cnt = 0;
      pending_o    <= 0;
      checked_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // Retire the result first: it always belongs to an earlier input.
      if (out_valid_i && out_ready_i) begin
        if (coef_expected_q.size() == 0) begin
          log_mismatch("unexpected result", '0, coefficient_i);
        end else begin
          checked_cnt++;
          if (coefficient_i !== coef_expected_q[0]) begin
            log_mismatch("coefficient", coef_expected_q[0], coefficient_i);
          end
          void'(coef_expected_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        coef_expected_q.push_back(binomial_of(set_size_i, pick_count_i));
      end
      pending_o    <= coef_expected_q.size();
      checked_o    <= checked_cnt;
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the binomial coefficient testbench: clock, reset, stimulus and verdict.
// Depends on bc_pkg, binomial_coefficient_top and binomial_coefficient_checker.
module testbench;
  import bc_pkg::*;

  // Run shape
  localparam int unsigned DIRECTED_PAIRS = 25;
  localparam int unsigned RANDOM_PAIRS   = 1375;
  localparam int unsigned HOLD_CYCLES    = 1500;     // long output hold-off, well past latency
  localparam int unsigned HOLD_AFTER     = 200;      // start the hold-off after this many pairs
  localparam int unsigned DRAIN_CYCLES   = 400;      // drain wait, longer than the worst-case latency
  // Slowest correct run: every pair at the worst-case latency plus the longest gap and the
  // longest stall, plus the hold-off; take that about four times over.
  localparam int unsigned CYCLE_LIMIT    = 3_000_000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic [N_W-1:0]    set_size_i    = '0;
  logic [N_W-1:0]    pick_count_i  = '0;
  logic              out_ready_i   = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [COEF_W-1:0] coefficient_o;

  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned mismatch_cnt;
  int unsigned pairs_sent = 0;
  int unsigned cycle_cnt  = 0;
  logic        hold_off   = 1'b0;
  bit          calm_tx    = 1'b0;

  // Directed pairs: both field extremes, k = 0, k above n, the symmetric
  // reduction on both sides of n/2, the largest result and alternating bit patterns.
  logic [N_W-1:0] directed_n [DIRECTED_PAIRS] = '{
    6'd0,  6'd63, 6'd0,  6'd63, 6'd63, 6'd63, 6'd62, 6'd63, 6'd63, 6'd1,
    6'd1,  6'd2,  6'd10, 6'd5,  6'd62, 6'd42, 6'd42, 6'd50, 6'd21, 6'd31,
    6'd32, 6'd60, 6'd61, 6'd7,  6'd45
  };
  logic [N_W-1:0] directed_k [DIRECTED_PAIRS] = '{
    6'd0,  6'd0,  6'd63, 6'd63, 6'd31, 6'd32, 6'd31, 6'd1,  6'd62, 6'd0,
    6'd1,  6'd1,  6'd11, 6'd63, 6'd63, 6'd0,  6'd21, 6'd25, 6'd42, 6'd15,
    6'd16, 6'd30, 6'd30, 6'd3,  6'd22
  };

  binomial_coefficient_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .set_size_i    (set_size_i),
    .pick_count_i  (pick_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o)
  );

  binomial_coefficient_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .set_size_i    (set_size_i),
    .pick_count_i  (pick_count_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_i (coefficient_o),
    .pending_o     (pending_cnt),
    .checked_o     (checked_cnt),
    .mismatches_o  (mismatch_cnt)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt, pending_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // Idle length shared by both sides: mostly short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one pair and hold it until accepted, then optionally idle the channel.
  // Values read right after the edge are the pre-edge values, so the handshake
  // test matches what the block saw.
  task automatic send_pair(logic [N_W-1:0] n, logic [N_W-1:0] k);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    set_size_i   <= n;
    pick_count_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
    // Flip between quiet stretches and gappy ones now and then.
    if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
    gap = (!calm_tx && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random stalls, quiet stretches, and the long hold-off when asked.
  initial begin
    int unsigned stall_left;
    bit          calm_rx;
    stall_left = 0;
    calm_rx    = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm_rx && $urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  // Hold the output off for a long stretch while the sender keeps offering, so the
  // result register fills and the input stalls.
  initial begin
    wait (pairs_sent >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Stimulus and verdict
  initial begin
    int unsigned    r;
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_PAIRS; i++) begin
      send_pair(directed_n[i], directed_k[i]);
    end

    // Mostly k within n, some k above n, and some raw 6-bit values.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = N_W'($urandom_range(0, 63));
        k = N_W'($urandom_range(0, n));
      end else if (r < 75) begin
        n = N_W'($urandom_range(0, 62));
        k = N_W'($urandom_range(n + 1, 63));
      end else begin
        n = N_W'($urandom);
        k = N_W'($urandom);
      end
      send_pair(n, k);
    end
    in_valid_i <= 1'b0;

    // Let the last transaction register, drain, then watch for stray results.
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d of %0d (n, k) pairs: field extremes, k = 0, k above n, both sides",
             checked_cnt, pairs_sent);
    $display("of n/2 and random pairs, under random gaps, stalls and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
